### rtl/isc_pkg.sv
package isc_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FIELD_W     = 27;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned HIST_W      = 64;

  // Default width of the internal byte counter.
  localparam int unsigned OFFSET_BITS_DEF = 27;

  // Signatures and limits of the three image formats.
  localparam logic [63:0] PNG_SIG      = 64'h89504E470D0A1A0A;
  localparam logic [63:0] PNG_TRAILER  = 64'h49454E44AE426082;
  localparam logic [23:0] JPEG_SIG     = 24'hFFD8FF;
  localparam logic [15:0] JPEG_TRAILER = 16'hFFD9;
  localparam logic [7:0]  BMP_B        = 8'h42;
  localparam logic [7:0]  BMP_M        = 8'h4D;
  localparam logic [31:0] BMP_MIN_SIZE = 32'd14;
  localparam logic [31:0] BMP_MAX_SIZE = 32'd52428800;

  // Minimum distance from a header start to the last byte of its trailer.
  localparam int unsigned JPEG_GAP = 4;
  localparam int unsigned PNG_GAP  = 15;

  typedef enum logic [KIND_W-1:0] {
    KIND_JPEG = 2'd0,
    KIND_PNG  = 2'd1,
    KIND_BMP  = 2'd2
  } kind_e;

  // One carved image.
  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } res_t;

  // All results caused by one byte, first one in r0.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_res_t;

endpackage

### rtl/isc_byte_if.sv
interface isc_byte_if;
  logic                       valid;
  logic                       ready;
  logic [isc_pkg::BYTE_W-1:0] data_byte;
  logic                       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

### rtl/isc_result_if.sv
interface isc_result_if;
  logic                        valid;
  logic                        ready;
  logic [isc_pkg::KIND_W-1:0]  image_kind;
  logic [isc_pkg::FIELD_W-1:0] start_offset;
  logic [isc_pkg::FIELD_W-1:0] image_length;
  logic                        last_of_step;

  modport source (output valid, output image_kind, output start_offset,
                  output image_length, output last_of_step, input ready);
  modport sink (input valid, input image_kind, input start_offset,
                input image_length, input last_of_step, output ready);
endinterface

### rtl/isc_cfg_if.sv
interface isc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [isc_pkg::FIELD_W-1:0] stream_length;

  modport source (output valid, output stream_length, input ready);
  modport sink (input valid, input stream_length, output ready);
endinterface

### rtl/image_signature_carver.sv
// Image signature carver.
// A byte stream enters on byte_i, one request per byte; first_byte marks the
// first byte of a new stream and clears all scanners. JPEG, PNG and BMP
// scanners run side by side and each carved image comes out on result_o as
// kind, start offset and length, with last_of_step set on the final result
// caused by one byte. A byte causes zero, one or two results.
// cfg_i writes stream_length, which bounds BMP candidates; write it only
// while no byte is in flight. cfg_i is always ready.
// Results of a byte enter the result buffer as it leaves the input
// register; a second result is shown once the first is taken. Throughput
// is one byte per cycle, set by the input register feeding the scanners
// and a two-entry result buffer; a byte that causes two results leaves one
// result queued, and a later byte waits only while its results do not fit.
// When the receiver stalls, results wait in the two buffer entries; a byte
// whose results do not fit is held in the input register and byte_i.ready
// stays low until an entry frees up.
// Reset clears stream_length, the scanners and both buffers.
module image_signature_carver #(
  parameter int unsigned OFFSET_BITS = isc_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  isc_byte_if.sink      byte_i,
  isc_cfg_if.sink       cfg_i,
  isc_result_if.source  result_o
);

  logic                        inq_valid_q;
  logic [isc_pkg::BYTE_W-1:0]  inq_byte_q;
  logic                        inq_first_q;
  logic [isc_pkg::FIELD_W-1:0] stream_length_q;
  logic                        accept, consume;
  logic [1:0]                  room;
  isc_pkg::step_res_t          step_res;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
    end else if (cfg_i.valid) begin
      stream_length_q <= cfg_i.stream_length;
    end
  end

  // Input register: a byte moves on once its results fit in the buffer.
  assign consume      = inq_valid_q && (step_res.cnt <= room);
  assign byte_i.ready = !inq_valid_q || consume;
  assign accept       = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (accept) begin
      inq_valid_q <= 1'b1;
    end else if (consume) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_byte_q  <= byte_i.data_byte;
      inq_first_q <= byte_i.first_byte;
    end
  end

  isc_scanner #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scanner (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (consume),
    .data_byte_i    (inq_byte_q),
    .first_byte_i   (inq_first_q),
    .stream_length_i(stream_length_q),
    .res_o          (step_res)
  );

  isc_result_buf u_result_buf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(consume),
    .res_i (step_res),
    .room_o(room),
    .out   (result_o)
  );

`ifndef ASSERT_OFF
  // After a consumed byte that causes results, result_o is valid on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && (step_res.cnt != 2'd0) |=> result_o.valid)
    else $error("result of consumed byte not presented");
`endif

endmodule

### rtl/isc_scanner.sv
module isc_scanner #(
  parameter int unsigned OFFSET_BITS = isc_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [isc_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        first_byte_i,
  input  logic [isc_pkg::FIELD_W-1:0] stream_length_i,
  output isc_pkg::step_res_t          res_o
);

  localparam int unsigned PW = OFFSET_BITS + 1;
  localparam int unsigned BW = ((OFFSET_BITS > 27) ? OFFSET_BITS : 27) + 1;
  localparam int unsigned SW = ((OFFSET_BITS > 26) ? OFFSET_BITS : 26) + 1;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  // Scanner state.
  logic [OFFSET_BITS-1:0]    pos_q, pos_d;
  logic [isc_pkg::HIST_W-1:0] hist_q, hist_d;
  logic                      jin_q, jin_d;
  logic [OFFSET_BITS-1:0]    jst_q, jst_d;
  logic                      pin_q, pin_d;
  logic [OFFSET_BITS-1:0]    pst_q, pst_d;
  logic [SW-1:0]             skip_q, skip_d;

  // State as seen by the current byte, after a new-stream clear.
  logic [OFFSET_BITS-1:0]    pos_c;
  logic [isc_pkg::HIST_W-1:0] hist_c;
  logic                      jin_c;
  logic [OFFSET_BITS-1:0]    jst_c;
  logic                      pin_c;
  logic [OFFSET_BITS-1:0]    pst_c;
  logic [SW-1:0]             skip_c;

  logic                      jpeg_done, jpeg_open, png_done, png_open;
  logic                      bmp_hdr, bmp_ok;
  logic [OFFSET_BITS-1:0]    bmp_pos;
  logic [31:0]               bmp_size;
  logic [BW-1:0]             bmp_pos_w, bmp_end_w, bmp_hdr_end_w;
  logic [PW-1:0]             jpeg_len, png_len;
  isc_pkg::res_t             pri_res, bmp_res;
  logic                      has_pri;

  // Zero-extend or truncate a counter value to the output field width.
  function automatic logic [isc_pkg::FIELD_W-1:0] to_field(input logic [32:0] v);
    to_field = v[isc_pkg::FIELD_W-1:0];
  endfunction

  always_comb begin
    if (first_byte_i) begin
      pos_c  = '0;
      hist_c = '0;
      jin_c  = 1'b0;
      jst_c  = '0;
      pin_c  = 1'b0;
      pst_c  = '0;
      skip_c = '0;
    end else begin
      pos_c  = pos_q;
      hist_c = hist_q;
      jin_c  = jin_q;
      jst_c  = jst_q;
      pin_c  = pin_q;
      pst_c  = pst_q;
      skip_c = skip_q;
    end
  end

  assign hist_d = {hist_c[isc_pkg::HIST_W-isc_pkg::BYTE_W-1:0], data_byte_i};

  // JPEG scanner: header opens, trailer at least four bytes on closes.
  assign jpeg_done = jin_c && (hist_d[15:0] == isc_pkg::JPEG_TRAILER) &&
                     (PW'(pos_c) >= PW'(jst_c) + PW'(isc_pkg::JPEG_GAP));
  assign jpeg_open = !jin_c && (hist_d[23:0] == isc_pkg::JPEG_SIG) &&
                     (PW'(pos_c) >= PW'(2));
  assign jpeg_len  = PW'(pos_c) - PW'(jst_c) + PW'(1);

  // PNG scanner: same structure with eight-byte patterns.
  assign png_done = pin_c && (hist_d == isc_pkg::PNG_TRAILER) &&
                    (PW'(pos_c) >= PW'(pst_c) + PW'(isc_pkg::PNG_GAP));
  assign png_open = !pin_c && (hist_d == isc_pkg::PNG_SIG) &&
                    (PW'(pos_c) >= PW'(7));
  assign png_len  = PW'(pos_c) - PW'(pst_c) + PW'(1);

  // BMP scanner: "BM" five bytes back, then a little-endian size.
  assign bmp_hdr  = (PW'(pos_c) >= PW'(5)) && (hist_d[47:40] == isc_pkg::BMP_B) &&
                    (hist_d[39:32] == isc_pkg::BMP_M);
  assign bmp_pos  = pos_c - OFFSET_BITS'(5);
  assign bmp_size = {hist_d[7:0], hist_d[15:8], hist_d[23:16], hist_d[31:24]};
  assign bmp_pos_w     = BW'(bmp_pos);
  assign bmp_hdr_end_w = bmp_pos_w + BW'(isc_pkg::BMP_MIN_SIZE);
  assign bmp_end_w     = bmp_pos_w + BW'(bmp_size[25:0]);
  assign bmp_ok = bmp_hdr && (bmp_pos_w >= BW'(skip_c)) &&
                  (bmp_hdr_end_w <= BW'(stream_length_i)) &&
                  (bmp_size >= isc_pkg::BMP_MIN_SIZE) &&
                  (bmp_size < isc_pkg::BMP_MAX_SIZE) &&
                  (bmp_end_w <= BW'(stream_length_i));

  // Next state.
  always_comb begin
    jin_d  = jin_c ? !jpeg_done : jpeg_open;
    jst_d  = jpeg_open ? (pos_c - OFFSET_BITS'(2)) : jst_c;
    pin_d  = pin_c ? !png_done : png_open;
    pst_d  = png_open ? (pos_c - OFFSET_BITS'(7)) : pst_c;
    skip_d = bmp_ok ? bmp_end_w[SW-1:0] : skip_c;
    pos_d  = (pos_c < POS_MAX) ? (pos_c + OFFSET_BITS'(1)) : POS_MAX;
  end

  // Results in kind order: JPEG or PNG first, then BMP.
  always_comb begin
    has_pri        = jpeg_done || png_done;
    pri_res.kind   = jpeg_done ? isc_pkg::KIND_JPEG : isc_pkg::KIND_PNG;
    pri_res.start  = jpeg_done ? to_field(33'(jst_c)) : to_field(33'(pst_c));
    pri_res.length = jpeg_done ? to_field(33'(jpeg_len)) : to_field(33'(png_len));
    pri_res.last   = !bmp_ok;
    bmp_res.kind   = isc_pkg::KIND_BMP;
    bmp_res.start  = to_field(33'(bmp_pos));
    bmp_res.length = bmp_size[isc_pkg::FIELD_W-1:0];
    bmp_res.last   = 1'b1;
    res_o.cnt      = 2'({1'b0, has_pri}) + 2'({1'b0, bmp_ok});
    res_o.r0       = has_pri ? pri_res : bmp_res;
    res_o.r1       = bmp_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hist_q <= '0;
      jin_q  <= 1'b0;
      jst_q  <= '0;
      pin_q  <= 1'b0;
      pst_q  <= '0;
      skip_q <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      hist_q <= hist_d;
      jin_q  <= jin_d;
      jst_q  <= jst_d;
      pin_q  <= pin_d;
      pst_q  <= pst_d;
      skip_q <= skip_d;
    end
  end

`ifndef ASSERT_OFF
  // A new-stream byte always leaves the counter at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && first_byte_i |=> pos_q == OFFSET_BITS'(1))
    else $error("byte counter not restarted by new stream");

  // A JPEG and a PNG trailer can never end on the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(jpeg_done && png_done))
    else $error("JPEG and PNG closed on one byte");
`endif

endmodule

### rtl/isc_result_buf.sv
module isc_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  isc_pkg::step_res_t res_i,
  output logic [1:0]         room_o,
  isc_result_if.source       out
);

  logic [1:0]    n_q, n_d;
  isc_pkg::res_t s0_q, s0_d, s1_q, s1_d;
  logic          pop;
  logic [1:0]    rem;
  logic [1:0]    push_cnt;
  isc_pkg::res_t head;

  assign pop      = (n_q != 2'd0) && out.ready;
  assign rem      = n_q - 2'({1'b0, pop});
  assign room_o   = 2'd2 - rem;
  assign push_cnt = push_i ? res_i.cnt : 2'd0;
  assign head     = pop ? s1_q : s0_q;

  // Shift out the taken result and append the new ones behind the rest.
  always_comb begin
    n_d = rem + push_cnt;
    case (rem)
      2'd2: begin
        s0_d = s0_q;
        s1_d = s1_q;
      end
      2'd1: begin
        s0_d = head;
        s1_d = res_i.r0;
      end
      default: begin
        s0_d = res_i.r0;
        s1_d = res_i.r1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= 2'd0;
    end else begin
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign out.valid        = (n_q != 2'd0);
  assign out.image_kind   = s0_q.kind;
  assign out.start_offset = s0_q.start;
  assign out.image_length = s0_q.length;
  assign out.last_of_step = s0_q.last;

`ifndef ASSERT_OFF
  // The two slots never overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q != 2'd3)
    else $error("result buffer overflow");

  // The second result of a byte is already waiting when the first is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out.valid && out.ready && !out.last_of_step |=> out.valid)
    else $error("second result of a byte missing");
`endif

endmodule
